// ===== hw/rtl/gpio_interrupt_register_block_macros.svh =====
// Assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef GPIO_INTERRUPT_REGISTER_BLOCK_MACROS_SVH
`define GPIO_INTERRUPT_REGISTER_BLOCK_MACROS_SVH

`define GIRB_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define GIRB_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/gir_pkg.sv =====
`default_nettype none
package gir_pkg;

	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_PIN   = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	localparam int LOW_BITS  = 32;
	localparam int HIGH_BITS = 8;
	localparam int MAX_PINS  = 40;

	localparam logic [11:0] ADDR_OUT        = 12'h004;
	localparam logic [11:0] ADDR_OUT_SET    = 12'h008;
	localparam logic [11:0] ADDR_OUT_CLR    = 12'h00C;
	localparam logic [11:0] ADDR_EN         = 12'h020;
	localparam logic [11:0] ADDR_EN_SET     = 12'h024;
	localparam logic [11:0] ADDR_EN_CLR     = 12'h028;
	localparam logic [11:0] ADDR_STRAP      = 12'h038;
	localparam logic [11:0] ADDR_IN_LOW     = 12'h03C;
	localparam logic [11:0] ADDR_IN_HIGH    = 12'h040;
	localparam logic [11:0] ADDR_STAT_LOW   = 12'h044;
	localparam logic [11:0] ADDR_STAT_L_SET = 12'h048;
	localparam logic [11:0] ADDR_STAT_L_CLR = 12'h04C;
	localparam logic [11:0] ADDR_STAT_HIGH  = 12'h050;
	localparam logic [11:0] ADDR_STAT_H_SET = 12'h054;
	localparam logic [11:0] ADDR_STAT_H_CLR = 12'h058;
	localparam logic [11:0] ADDR_APP_LOW    = 12'h060;
	localparam logic [11:0] ADDR_PRO_LOW    = 12'h068;
	localparam logic [11:0] ADDR_APP_HIGH   = 12'h074;
	localparam logic [11:0] ADDR_PRO_HIGH   = 12'h07C;
	localparam logic [11:0] CFG_BASE        = 12'h088;
	localparam logic [11:0] CFG_END         = 12'h130;

	localparam int WIN_SLOTS = int'((CFG_END - CFG_BASE) >> 2);

	localparam int TRIG_LSB    = 7;
	localparam int PRO_EN_BIT  = 15;
	localparam int APP_EN_BIT  = 13;

	localparam logic [2:0] TRIG_RISE = 3'd1;
	localparam logic [2:0] TRIG_FALL = 3'd2;
	localparam logic [2:0] TRIG_ANY  = 3'd3;
	localparam logic [2:0] TRIG_LOW  = 3'd4;
	localparam logic [2:0] TRIG_HIGH = 3'd5;

	localparam logic [0:0] CFG_STRAP_DEFAULT = 1'b0;

	localparam logic [31:0] STRAP_RST   = 32'd18;
	localparam logic [31:0] IN_LOW_RST  = 32'h0000_0001;
	localparam logic [7:0]  IN_HIGH_RST = 8'h08;

	typedef struct packed {
		op_t         op;
		logic [11:0] address;
		logic [31:0] write_data;
		logic [5:0]  pin_index;
		logic        pin_level;
	} item_t;

	typedef struct packed {
		logic [31:0] out_val;
		logic [31:0] out_en;
		logic [31:0] strap;
		logic [31:0] in_low;
		logic [7:0]  in_high;
		logic [31:0] stat_low;
		logic [31:0] stat_high;
		logic [31:0] pro_low;
		logic [31:0] app_low;
		logic [7:0]  pro_high;
		logic [7:0]  app_high;
		logic        irq;
	} state_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq;
		logic [31:0] drive;
		logic [31:0] drive_mask;
		logic [31:0] dir;
		logic [31:0] dir_mask;
		logic        sync;
		logic        win_rd;
	} res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/gir_ram.sv =====
`default_nettype none
module gir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 40
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/gir_trig.sv =====
`default_nettype none
module gir_trig
	import gir_pkg::*;
#(
	parameter int SLOTS = 40,
	parameter int SW    = 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   we,
	input  wire logic [SW-1:0]          slot,
	input  wire logic [31:0]            wdata,
	output logic      [SLOTS-1:0][2:0]  kind_q,
	output logic      [SLOTS-1:0]       pro_en_q,
	output logic      [SLOTS-1:0]       app_en_q,
	output logic      [SLOTS-1:0]       valid_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= '0;
			pro_en_q <= '0;
			app_en_q <= '0;
			valid_q  <= '0;
		end else if (we) begin
			kind_q[slot]   <= wdata[TRIG_LSB +: 3];
			pro_en_q[slot] <= wdata[PRO_EN_BIT];
			app_en_q[slot] <= wdata[APP_EN_BIT];
			valid_q[slot]  <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/gir_step.sv =====
`default_nettype none
module gir_step
	import gir_pkg::*;
#(
	parameter int SLOTS = 40,
	parameter int SW    = 6
) (
	input  wire item_t                 item,
	input  wire state_t                st,
	input  wire logic [SLOTS-1:0][2:0] kind,
	input  wire logic [SLOTS-1:0]      pro_en,
	input  wire logic [SLOTS-1:0]      app_en,
	output state_t                     st_nx,
	output res_t                       res,
	output logic                       win_hit,
	output logic [SW-1:0]              win_slot
);

	localparam int EVT_PINS = (SLOTS < MAX_PINS) ? SLOTS : MAX_PINS;

	logic [11:0]          off;
	logic [9:0]           n;
	logic [LOW_BITS-1:0]  hold_low;
	logic [HIGH_BITS-1:0] hold_high;
	logic                 pin_ok;
	logic [SW-1:0]        pidx;
	logic                 is_high;
	logic [2:0]           hb;
	logic [4:0]           lb;
	logic                 prev_lvl;
	logic                 fire;
	logic [2:0]           pk;
	logic [31:0]          v;
	logic [31:0]          dmask;

	assign off      = item.address - CFG_BASE;
	assign n        = off[11:2];
	assign win_hit  = (item.address >= CFG_BASE) && (item.address < CFG_END) &&
		(n < 10'(SLOTS));
	assign win_slot = n[SW-1:0];

	for (genvar i = 0; i < LOW_BITS; i++) begin : g_hold_low
		assign hold_low[i] = ((kind[i] == TRIG_LOW) && !st.in_low[i]) ||
			((kind[i] == TRIG_HIGH) && st.in_low[i]);
	end

	for (genvar j = 0; j < HIGH_BITS; j++) begin : g_hold_high
		if (j + LOW_BITS < EVT_PINS) begin : g_pin
			assign hold_high[j] = ((kind[j+LOW_BITS] == TRIG_LOW) && !st.in_high[j]) ||
				((kind[j+LOW_BITS] == TRIG_HIGH) && st.in_high[j]);
		end else begin : g_none
			assign hold_high[j] = 1'b0;
		end
	end

	assign pin_ok   = item.pin_index < 6'(EVT_PINS);
	assign pidx     = item.pin_index[SW-1:0];
	assign is_high  = item.pin_index[5];
	assign hb       = item.pin_index[2:0];
	assign lb       = item.pin_index[4:0];
	assign prev_lvl = is_high ? st.in_high[hb] : st.in_low[lb];
	assign v        = item.write_data;

	always_comb begin
		pk = '0;
		if (pin_ok) begin
			pk = kind[pidx];
		end
		unique case (pk)
			TRIG_RISE: fire = item.pin_level && !prev_lvl;
			TRIG_FALL: fire = !item.pin_level && prev_lvl;
			TRIG_ANY:  fire = item.pin_level != prev_lvl;
			TRIG_LOW:  fire = !item.pin_level;
			TRIG_HIGH: fire = item.pin_level;
			default:   fire = 1'b0;
		endcase
	end

	always_comb begin
		st_nx = st;
		res   = '0;
		dmask = '0;
		unique case (item.op)
			OP_READ: begin
				res.win_rd = win_hit;
				if (!win_hit) begin
					unique case (item.address)
						ADDR_OUT:       res.read_data = st.out_val;
						ADDR_EN:        res.read_data = st.out_en;
						ADDR_STRAP:     res.read_data = st.strap;
						ADDR_IN_LOW: begin
							res.read_data = st.in_low;
							res.sync      = 1'b1;
						end
						ADDR_IN_HIGH: begin
							res.read_data = {24'd0, st.in_high};
							res.sync      = 1'b1;
						end
						ADDR_STAT_LOW:  res.read_data = st.stat_low;
						ADDR_STAT_HIGH: res.read_data = st.stat_high;
						ADDR_APP_LOW:   res.read_data = st.app_low;
						ADDR_PRO_LOW:   res.read_data = st.pro_low;
						ADDR_APP_HIGH:  res.read_data = {24'd0, st.app_high};
						ADDR_PRO_HIGH:  res.read_data = {24'd0, st.pro_high};
						default:        res.read_data = '0;
					endcase
				end
			end
			OP_WRITE: begin
				if (!win_hit) begin
					unique case (item.address)
						ADDR_OUT:        st_nx.out_val = v;
						ADDR_OUT_SET:    st_nx.out_val = st.out_val | v;
						ADDR_OUT_CLR:    st_nx.out_val = st.out_val & ~v;
						ADDR_EN:         st_nx.out_en = v;
						ADDR_EN_SET:     st_nx.out_en = st.out_en | v;
						ADDR_EN_CLR:     st_nx.out_en = st.out_en & ~v;
						ADDR_STRAP:      st_nx.strap = v;
						ADDR_STAT_LOW:   st_nx.stat_low = v;
						ADDR_STAT_L_SET: st_nx.stat_low = st.stat_low | v;
						ADDR_STAT_L_CLR: begin
							if (!(|(v & hold_low))) begin
								st_nx.stat_low = st.stat_low & ~v;
								st_nx.pro_low  = st.pro_low & ~v;
								st_nx.app_low  = st.app_low & ~v;
								st_nx.irq      = 1'b0;
							end
						end
						ADDR_STAT_HIGH:  st_nx.stat_high = v;
						ADDR_STAT_H_SET: st_nx.stat_high = st.stat_high | v;
						ADDR_STAT_H_CLR: begin
							if (!(|(v[HIGH_BITS-1:0] & hold_high))) begin
								st_nx.stat_high = st.stat_high & ~v;
								st_nx.pro_high  = st.pro_high & ~v[HIGH_BITS-1:0];
								st_nx.app_high  = st.app_high & ~v[HIGH_BITS-1:0];
								st_nx.irq       = 1'b0;
							end
						end
						default: ;
					endcase
				end
				dmask = ((st_nx.out_val ^ st.out_val) | (st_nx.out_en ^ st.out_en)) &
					st_nx.out_en;
				st_nx.in_low   = (st_nx.in_low & ~dmask) | (st_nx.out_val & dmask);
				res.drive_mask = dmask;
				res.dir_mask   = st_nx.out_en ^ st.out_en;
			end
			OP_PIN: begin
				if (pin_ok) begin
					if (is_high) begin
						st_nx.in_high[hb] = item.pin_level;
					end else begin
						st_nx.in_low[lb] = item.pin_level;
					end
					if (fire && pro_en[pidx]) begin
						st_nx.irq = 1'b1;
						if (is_high) begin
							st_nx.pro_high[hb] = 1'b1;
						end else begin
							st_nx.pro_low[lb] = 1'b1;
						end
					end
					if (fire && app_en[pidx]) begin
						st_nx.irq = 1'b1;
						if (is_high) begin
							st_nx.app_high[hb] = 1'b1;
						end else begin
							st_nx.app_low[lb] = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		res.irq   = st_nx.irq;
		res.drive = st_nx.out_val;
		res.dir   = st_nx.out_en;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/gpio_interrupt_register_block.sv =====
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  tuser: operation; tdata: address..pin_level
// m_       out  m_tvalid/m_tready  tdata: read_data..sync_request
// apb      in   psel/penable       strap_default where paddr[2] is 0
//
// One item per clock while the output is not stalled; an item waits in the input
// register and its result is loaded into the output register when it advances.
// Pin settings window reads come from the settings RAM's registered port.
// Reset puts control and register state to its reset values at once, with no sweep.
// A stalled output holds its item; the input register then takes one only if empty.
`default_nettype none
module gpio_interrupt_register_block
	import gir_pkg::*;
#(
	parameter int PIN_COUNT = 40
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// [11:0] address, [43:12] write_data, [49:44] pin_index, [50] pin_level
	input  wire logic [55:0]  s_tdata,
	// [1:0] operation
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [31:0] read_data, [32] irq_level, [64:33] drive_levels,
	// [96:65] drive_update_mask, [128:97] direction_levels,
	// [160:129] direction_update_mask, [161] sync_request
	output logic      [167:0] m_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready
);

	localparam int SLOTS = (PIN_COUNT < WIN_SLOTS) ? PIN_COUNT : WIN_SLOTS;
	localparam int SW    = $clog2(SLOTS);

	item_t                 item_s1;
	logic                  valid_s1;
	res_t                  res_s2;
	logic                  valid_s2;
	state_t                st_q;
	state_t                st_nx;
	res_t                  res;
	res_t                  res_in;
	logic [31:0]           strap_default_q;
	logic                  advance;
	logic                  cfg_wr;
	logic                  win_hit;
	logic [SW-1:0]         win_slot;
	logic [SLOTS-1:0][2:0] kind_q;
	logic [SLOTS-1:0]      pro_en_q;
	logic [SLOTS-1:0]      app_en_q;
	logic [SLOTS-1:0]      valid_q;
	logic                  win_we;
	logic                  win_re;
	logic [31:0]           ram_rdata;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready &&
		(paddr[2:2] == CFG_STRAP_DEFAULT);
	assign prdata   = (paddr[2:2] == CFG_STRAP_DEFAULT) ? strap_default_q : '0;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (!valid_s2 || m_tready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op         <= op_t'(s_tuser);
			item_s1.address    <= s_tdata[11:0];
			item_s1.write_data <= s_tdata[43:12];
			item_s1.pin_index  <= s_tdata[49:44];
			item_s1.pin_level  <= s_tdata[50];
		end
		if (advance) begin
			res_s2 <= res_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strap_default_q <= STRAP_RST;
			st_q            <= '{
				out_val:   '0,
				out_en:    '0,
				strap:     STRAP_RST,
				in_low:    IN_LOW_RST,
				in_high:   IN_HIGH_RST,
				stat_low:  '0,
				stat_high: '0,
				pro_low:   '0,
				app_low:   '0,
				pro_high:  '0,
				app_high:  '0,
				irq:       1'b0
			};
		end else if (cfg_wr) begin
			strap_default_q <= pwdata;
			st_q.strap      <= pwdata;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	gir_step #(
		.SLOTS(SLOTS),
		.SW   (SW)
	) u_step (
		.item    (item_s1),
		.st      (st_q),
		.kind    (kind_q),
		.pro_en  (pro_en_q),
		.app_en  (app_en_q),
		.st_nx   (st_nx),
		.res     (res),
		.win_hit (win_hit),
		.win_slot(win_slot)
	);

	always_comb begin
		res_in        = res;
		res_in.win_rd = res.win_rd && valid_q[win_slot];
	end

	assign win_we = advance && (item_s1.op == OP_WRITE) && win_hit;
	assign win_re = advance && (item_s1.op == OP_READ) && win_hit;

	gir_trig #(
		.SLOTS(SLOTS),
		.SW   (SW)
	) u_trig (
		.clk     (clk),
		.arst_n  (arst_n),
		.we      (win_we),
		.slot    (win_slot),
		.wdata   (item_s1.write_data),
		.kind_q  (kind_q),
		.pro_en_q(pro_en_q),
		.app_en_q(app_en_q),
		.valid_q (valid_q)
	);

	gir_ram #(
		.WIDTH(32),
		.DEPTH(SLOTS)
	) u_settings (
		.clk  (clk),
		.we   (win_we),
		.re   (win_re),
		.addr (win_slot),
		.wdata(item_s1.write_data),
		.rdata(ram_rdata)
	);

	assign m_tdata[31:0]    = res_s2.win_rd ? ram_rdata : res_s2.read_data;
	assign m_tdata[32]      = res_s2.irq;
	assign m_tdata[64:33]   = res_s2.drive;
	assign m_tdata[96:65]   = res_s2.drive_mask;
	assign m_tdata[128:97]  = res_s2.dir;
	assign m_tdata[160:129] = res_s2.dir_mask;
	assign m_tdata[161]     = res_s2.sync;
	assign m_tdata[167:162] = '0;

`include "gpio_interrupt_register_block_macros.svh"

	`GIRB_ASSERT_IMP(a_stall_means_busy, !s_tready, valid_s1, "input stalled while empty")
	`GIRB_ASSERT_IMP(a_result_tracks_state, valid_s2 && !cfg_wr, (res_s2.irq == st_q.irq) && (res_s2.drive == st_q.out_val) && (res_s2.dir == st_q.out_en), "result out of step with state")
	`GIRB_ASSERT_IMP(a_irq_drop_on_write, advance && st_q.irq && !st_nx.irq, item_s1.op == OP_WRITE, "irq dropped by a non-write item")
	`GIRB_ASSERT_NXT(a_window_read_holds, m_tvalid && !m_tready && res_s2.win_rd, $stable(ram_rdata), "settings read data moved under stall")

endmodule
`default_nettype wire
